### hw/rtl/rdq_pkg.sv
// Shared types, constants and helpers for the relay descriptor queue.
`timescale 1ns / 1ps
`default_nettype none

package rdq_pkg;

    localparam int DEPTH          = 16;
    localparam int MAX_PACKET_LEN = 4096;
    localparam int IDX_W          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int KIND_W         = 3;
    localparam int IN_DATA_W      = 384;
    localparam int OUT_DATA_W     = 320;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH          = 3'd0,
        KIND_POP           = 3'd1,
        KIND_PURGE_SESSION = 3'd2,
        KIND_PURGE_EXPIRED = 3'd3,
        KIND_CLEAR         = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PURGE,
        ST_HOLD
    } state_t;

    // Request as carried on s_tdata, first member in the top bits.
    typedef struct packed {
        logic [63:0] now_time;
        logic [63:0] delay_until;
        logic [63:0] expiry_time;
        logic [63:0] packet_id;
        logic [63:0] session_id;
        logic [15:0] buffer_capacity;
        logic [15:0] packet_length;
        logic [31:0] buffer_handle;
    } req_t;

    // One stored descriptor.
    typedef struct packed {
        logic [63:0] delay;
        logic [63:0] expiry;
        logic [63:0] packet_id;
        logic [63:0] session;
        logic [15:0] length;
        logic [31:0] handle;
    } entry_t;

    // Result as carried on m_tdata.
    typedef struct packed {
        logic [2:0]       pad;
        logic             is_full;
        logic             is_empty;
        logic [CNT_W-1:0] occupancy;
        logic [CNT_W-1:0] removed_count;
        logic [63:0]      out_delay;
        logic [63:0]      out_expiry;
        logic [63:0]      out_packet_id;
        logic [63:0]      out_session;
        logic [15:0]      out_length;
        logic [31:0]      out_handle;
        logic             accepted;
    } res_t;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/relay_descriptor_queue_with_purge_core.sv
// Relay descriptor queue with purge: top level.
//
// Requests enter on the s_ channel (s_tuser = request kind, s_tdata = descriptor
// and keys); one result per request leaves on the m_ channel. Descriptors live
// in a single 16-entry synchronous RAM with one read and one write port.
//
// Request handling:
//   push, pop, clear, unknown kind : request registered, then result registered
//                                    in the output register
//   purge by session / by expiry   : walks the entries present at start; the
//                                    walk reads one entry per cycle
//                                    through the RAM read port and compacts kept ones.
// One request is in work at a time; a new request is taken once the previous
// one has produced its result, even while that result still waits in the
// output register (a second result waits in a hold register).
//
// Reset: head, tail and occupancy clear at once; RAM contents are left as is
// and their values are never used before written.
// Receiver stall: m_tdata holds until taken; the block then stops taking
// requests after the next one completes.
`timescale 1ns / 1ps
`default_nettype none

module relay_descriptor_queue_with_purge_core
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // buffer_handle, packet_length, buffer_capacity, session_id, packet_id,
    // expiry_time, delay_until, now_time
    input  wire logic [rdq_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind
    input  wire logic [rdq_pkg::KIND_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // accepted, out_handle, out_length, out_session, out_packet_id, out_expiry,
    // out_delay, removed_count, occupancy, is_empty, is_full, zero pad
    output logic [rdq_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import rdq_pkg::*;

    entry_t slot_mem [DEPTH];

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    kind_t            kind_reg, kind_next;
    req_t             req_reg, req_next;
    entry_t           rd_data_reg;
    res_t             hold_reg, hold_next;
    res_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    // purge walk
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] issued_reg, issued_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic             pend_reg, pend_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_wdata;
    entry_t           push_entry;

    res_t             res;
    logic             res_ready;
    logic             out_free;
    logic             push_ok;
    logic             drop;
    logic             issue;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign out_free = !out_valid_reg || m_tready;

    assign push_entry.delay     = req_reg.delay_until;
    assign push_entry.expiry    = req_reg.expiry_time;
    assign push_entry.packet_id = req_reg.packet_id;
    assign push_entry.session   = req_reg.session_id;
    assign push_entry.length    = req_reg.packet_length;
    assign push_entry.handle    = req_reg.buffer_handle;

    assign push_ok = (count_reg < CNT_W'(DEPTH))
                  && (req_reg.buffer_handle != '0)
                  && (req_reg.packet_length != '0)
                  && (req_reg.buffer_capacity >= req_reg.packet_length)
                  && (req_reg.packet_length <= 16'(MAX_PACKET_LEN))
                  && (req_reg.session_id != '0)
                  && (req_reg.packet_id != '0);

    assign issue = (issued_reg != total_reg);

    always_comb
    begin
        if (kind_reg == KIND_PURGE_SESSION)
        begin
            drop = (rd_data_reg.session == req_reg.session_id);
        end
        else
        begin
            drop = (rd_data_reg.expiry != '0) && (rd_data_reg.expiry <= req_reg.now_time);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        req_next       = req_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        total_next     = total_reg;
        issued_next    = issued_reg;
        kept_next      = kept_reg;
        rd_idx_next    = rd_idx_reg;
        pos_next       = pos_reg;
        wr_idx_next    = wr_idx_reg;
        pend_next      = pend_reg;
        mem_we         = 1'b0;
        mem_waddr      = tail_reg;
        mem_wdata      = push_entry;
        mem_raddr      = head_reg;
        res            = '0;
        res_ready      = 1'b0;
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    req_next   = req_t'(s_tdata);
                    kind_next  = kind_t'(s_tuser);
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                unique case (kind_reg) inside
                    KIND_PUSH:
                    begin
                        res_ready = 1'b1;
                        if (push_ok)
                        begin
                            mem_we       = 1'b1;
                            tail_next    = wrap_inc(tail_reg);
                            count_next   = count_reg + 1'b1;
                            res.accepted = 1'b1;
                        end
                    end
                    KIND_POP:
                    begin
                        res_ready = 1'b1;
                        // rd_data_reg holds the head entry read in the transfer cycle
                        if (count_reg != '0)
                        begin
                            res.accepted      = 1'b1;
                            res.out_handle    = rd_data_reg.handle;
                            res.out_length    = rd_data_reg.length;
                            res.out_session   = rd_data_reg.session;
                            res.out_packet_id = rd_data_reg.packet_id;
                            res.out_expiry    = rd_data_reg.expiry;
                            res.out_delay     = rd_data_reg.delay;
                            head_next         = wrap_inc(head_reg);
                            count_next        = count_reg - 1'b1;
                        end
                    end
                    KIND_PURGE_SESSION, KIND_PURGE_EXPIRED:
                    begin
                        total_next  = count_reg;
                        issued_next = '0;
                        kept_next   = '0;
                        rd_idx_next = head_reg;
                        wr_idx_next = head_reg;
                        pend_next   = 1'b0;
                        state_next  = ST_PURGE;
                    end
                    KIND_CLEAR:
                    begin
                        res_ready    = 1'b1;
                        res.accepted = 1'b1;
                        head_next    = '0;
                        tail_next    = '0;
                        count_next   = '0;
                    end
                    default:
                    begin
                        res_ready = 1'b1;
                    end
                endcase
            end

            ST_PURGE:
            begin
                // read stage runs one entry ahead of the keep/compact stage;
                // writes only land at or behind the entry being checked
                if (issue)
                begin
                    mem_raddr   = rd_idx_reg;
                    rd_idx_next = wrap_inc(rd_idx_reg);
                    issued_next = issued_reg + 1'b1;
                    pos_next    = rd_idx_reg;
                end
                pend_next = issue;
                if (pend_reg && !drop)
                begin
                    if (wr_idx_reg != pos_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = wr_idx_reg;
                        mem_wdata = rd_data_reg;
                    end
                    wr_idx_next = wrap_inc(wr_idx_reg);
                    kept_next   = kept_reg + 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    res_ready         = 1'b1;
                    res.accepted      = 1'b1;
                    res.removed_count = total_reg - kept_reg;
                    count_next        = kept_reg;
                    tail_next         = wr_idx_reg;
                end
            end

            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (res_ready)
        begin
            res.occupancy = count_next;
            res.is_empty  = (count_next == '0);
            res.is_full   = (count_next == CNT_W'(DEPTH));
            if (out_free)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            else
            begin
                hold_next  = res;
                state_next = ST_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            issued_reg    <= '0;
            kept_reg      <= '0;
            rd_idx_reg    <= '0;
            pos_reg       <= '0;
            wr_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            kind_reg      <= KIND_PUSH;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            issued_reg    <= issued_next;
            kept_reg      <= kept_next;
            rd_idx_reg    <= rd_idx_next;
            pos_reg       <= pos_next;
            wr_idx_reg    <= wr_idx_next;
            pend_reg      <= pend_next;
            kind_reg      <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

### hw/rtl/rdq_checker.sv
// Port-level checker for the relay descriptor queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rdq_checker
(
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rdq_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import rdq_pkg::*;

    res_t r;
    assign r = res_t'(m_tdata);

    // a stalled result transfer keeps its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken back to back");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (r.is_empty == (r.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (r.is_full == (r.occupancy == CNT_W'(DEPTH)))
        && (r.occupancy <= CNT_W'(DEPTH)))
        else $error("full flag or occupancy out of range");

    // a refused request never carries popped data or a purge count
    a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !r.accepted |-> (r.out_handle == '0) && (r.removed_count == '0))
        else $error("refused result carries data");

endmodule

bind relay_descriptor_queue_with_purge_core rdq_checker u_rdq_checker (.*);

`default_nettype wire
